FILE: rtl/ich_pkg.sv
package ich_pkg;

  localparam int unsigned HullDepthDef  = 64;
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned ArrW          = 32;
  localparam int unsigned PortW         = 32;
  localparam int unsigned CountW        = 7;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_INTERIOR  = 3'd2,
    ST_COLLINEAR = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_VERTEX    = 3'd5,
    ST_EMPTY     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OUT_POINT = 2'd0,
    OUT_VERT  = 2'd1,
    OUT_ZERO  = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic     ld_pt;
    logic     shift;
    logic     we;
    logic     wsrc_pt;
    logic     out_ld;
    out_sel_e out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic eq_a;
    logic eq_b;
    logic cross_pos;
    logic cross_zero;
  } dp_sts_t;

endpackage

FILE: rtl/ich_ram.sv
module ich_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ich_dp.sv
module ich_dp #(
  parameter int unsigned HULL_DEPTH  = ich_pkg::HullDepthDef,
  parameter int unsigned COORD_WIDTH = ich_pkg::CoordWidthDef,
  localparam int unsigned RamAw = $clog2(2 * HULL_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ich_pkg::PortW-1:0]   x_coord_i,
  input  logic [ich_pkg::PortW-1:0]   y_coord_i,
  input  ich_pkg::dp_cmd_t            cmd_i,
  input  logic [RamAw-1:0]            raddr_i,
  input  logic [RamAw-1:0]            waddr_i,
  output ich_pkg::dp_sts_t            sts_o,
  output logic [ich_pkg::ArrW-1:0]    vertex_number_o,
  output logic [ich_pkg::PortW-1:0]   vertex_x_o,
  output logic [ich_pkg::PortW-1:0]   vertex_y_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned AW32  = ich_pkg::ArrW;
  localparam int unsigned WordW = 2 * CW + AW32;
  localparam int unsigned PW    = 2 * CW + 2;

  logic signed [CW-1:0]   px_q, py_q, va_x_q, va_y_q, vb_x_q, vb_y_q;
  logic [AW32-1:0]        arr_q, next_arr_q, vb_arr_q;
  logic [WordW-1:0]       rdata, wdata;
  logic signed [CW:0]     dx1, dy1, dx2, dy2;
  logic signed [PW-1:0]   prod1_q, prod2_q;
  logic signed [PW:0]     diff_q;
  logic [AW32-1:0]        num_q;
  logic [ich_pkg::PortW-1:0] ox_q, oy_q;

  assign wdata = cmd_i.wsrc_pt ? {arr_q, px_q, py_q} : rdata;

  ich_ram #(
    .WIDTH (WordW),
    .DEPTH (2 * HULL_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (waddr_i),
    .wdata_i (wdata),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_arr_q <= AW32'(1);
    end else if (cmd_i.ld_pt) begin
      next_arr_q <= next_arr_q + 1'b1;
    end
  end

  // edge vector and point offset, both from the first vertex
  assign dx1 = {vb_x_q[CW-1], vb_x_q} - {va_x_q[CW-1], va_x_q};
  assign dy1 = {vb_y_q[CW-1], vb_y_q} - {va_y_q[CW-1], va_y_q};
  assign dx2 = {px_q[CW-1], px_q} - {va_x_q[CW-1], va_x_q};
  assign dy2 = {py_q[CW-1], py_q} - {va_y_q[CW-1], va_y_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_pt) begin
      px_q  <= x_coord_i[CW-1:0];
      py_q  <= y_coord_i[CW-1:0];
      arr_q <= next_arr_q;
    end
    if (cmd_i.shift) begin
      va_x_q   <= vb_x_q;
      va_y_q   <= vb_y_q;
      vb_arr_q <= rdata[WordW-1 -: AW32];
      vb_x_q   <= rdata[2*CW-1 -: CW];
      vb_y_q   <= rdata[CW-1:0];
    end
    prod1_q <= dx1 * dy2;
    prod2_q <= dx2 * dy1;
    diff_q  <= {prod1_q[PW-1], prod1_q} - {prod2_q[PW-1], prod2_q};
    if (cmd_i.out_ld) begin
      case (cmd_i.out_sel)
        ich_pkg::OUT_POINT: begin
          num_q <= arr_q;
          ox_q  <= ich_pkg::PortW'(px_q);
          oy_q  <= ich_pkg::PortW'(py_q);
        end
        ich_pkg::OUT_VERT: begin
          num_q <= vb_arr_q;
          ox_q  <= ich_pkg::PortW'(vb_x_q);
          oy_q  <= ich_pkg::PortW'(vb_y_q);
        end
        default: begin
          num_q <= '0;
          ox_q  <= '0;
          oy_q  <= '0;
        end
      endcase
    end
  end

  assign sts_o.eq_a       = (va_x_q == px_q) && (va_y_q == py_q);
  assign sts_o.eq_b       = (vb_x_q == px_q) && (vb_y_q == py_q);
  assign sts_o.cross_zero = (diff_q == '0);
  assign sts_o.cross_pos  = !diff_q[PW] && (diff_q != '0);

  assign vertex_number_o = num_q;
  assign vertex_x_o      = ox_q;
  assign vertex_y_o      = oy_q;

endmodule

FILE: rtl/ich_ctrl.sv
module ich_ctrl #(
  parameter int unsigned HULL_DEPTH = ich_pkg::HullDepthDef,
  localparam int unsigned RamAw = $clog2(2 * HULL_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        cmd_i,
  output logic                        busy_o,
  input  ich_pkg::dp_sts_t            sts_i,
  output ich_pkg::dp_cmd_t            dp_cmd_o,
  output logic [RamAw-1:0]            raddr_o,
  output logic [RamAw-1:0]            waddr_o,
  output logic                        result_valid_o,
  output logic [2:0]                  status_o,
  output logic [ich_pkg::CountW-1:0]  vertex_count_o,
  output logic                        last_o
);

  localparam int unsigned AW = $clog2(HULL_DEPTH);
  localparam int unsigned SW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_INS, S_ONE_SH, S_ONE_EQ,
    S_PRE_SH, S_PRE_SH2, S_PRE_W1, S_PRE_W2, S_PRE_US,
    S_L_RD, S_L_SH, S_L_EQ, S_L_W, S_L_US,
    S_CHK, S_T_SH, S_T_SH2, S_T_W1, S_T_W2, S_T_US,
    S_C_RD, S_C_WR, S_A_WR, S_COMMIT, S_FIN,
    S_RD0, S_R_RD, S_R_SH, S_R_EM
  } state_e;

  state_e                state_q;
  logic [SW-1:0]         size_q, k_q, j_q;
  logic [AW-1:0]         head_q, ptr_q, beg_q, end_q, gap_q, off_q;
  logic                  bank_q, x1pos_q, hb_q, he_q, add_q, first_q;
  ich_pkg::status_e      st_q;
  logic                  valid_q, last_q;
  logic [2:0]            status_q;
  logic [ich_pkg::CountW-1:0] count_q;

  logic [SW:0]           gap_t, off_t;
  logic [AW-1:0]         gap_c, off_c, prev_h, size_m1;

  function automatic logic [RamAw-1:0] slot_addr(input logic bank, input logic [AW-1:0] slot);
    logic [RamAw-1:0] base;
    base = bank ? RamAw'(HULL_DEPTH) : '0;
    return base + RamAw'(slot);
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p, input logic [SW-1:0] n);
    logic [SW-1:0] t;
    t = {1'b0, p} + 1'b1;
    return (t == n) ? '0 : t[AW-1:0];
  endfunction

  assign size_m1 = AW'(size_q - 1'b1);
  assign prev_h  = (head_q == '0) ? size_m1 : head_q - 1'b1;

  // ring distances, each needs at most one wrap correction
  assign gap_t = {2'b0, end_q} + {1'b0, size_q} - {2'b0, beg_q} - 1'b1;
  assign gap_c = (gap_t >= {1'b0, size_q}) ? AW'(gap_t - {1'b0, size_q}) : AW'(gap_t);
  assign off_t = {2'b0, head_q} + {1'b0, size_q} - {2'b0, beg_q};
  assign off_c = (off_t >= {1'b0, size_q}) ? AW'(off_t - {1'b0, size_q}) : AW'(off_t);

  always_comb begin
    dp_cmd_o = '0;
    raddr_o  = slot_addr(bank_q, ptr_q);
    waddr_o  = slot_addr(!bank_q, j_q[AW-1:0]);
    case (state_q)
      S_IDLE: dp_cmd_o.ld_pt = start_i && !cmd_i;
      S_INS: begin
        if (size_q == '0) begin
          dp_cmd_o.we      = 1'b1;
          dp_cmd_o.wsrc_pt = 1'b1;
          waddr_o          = slot_addr(bank_q, '0);
        end else if (size_q == SW'(1)) begin
          raddr_o = slot_addr(bank_q, '0);
        end else begin
          raddr_o = slot_addr(bank_q, prev_h);
        end
      end
      S_ONE_SH: dp_cmd_o.shift = 1'b1;
      S_ONE_EQ: begin
        dp_cmd_o.we      = 1'b1;
        dp_cmd_o.wsrc_pt = 1'b1;
        waddr_o          = slot_addr(bank_q, sts_i.eq_b ? AW'(0) : AW'(1));
      end
      S_PRE_SH: begin
        dp_cmd_o.shift = 1'b1;
        raddr_o        = slot_addr(bank_q, head_q);
      end
      S_PRE_SH2, S_L_SH, S_T_SH2, S_R_SH: dp_cmd_o.shift = 1'b1;
      S_L_RD: raddr_o = slot_addr(bank_q, wrap_inc(ptr_q, size_q));
      S_L_EQ: begin
        dp_cmd_o.we      = sts_i.eq_a;
        dp_cmd_o.wsrc_pt = 1'b1;
        waddr_o          = slot_addr(bank_q, ptr_q);
      end
      S_CHK: raddr_o = slot_addr(bank_q, beg_q);
      S_T_SH: begin
        dp_cmd_o.shift = 1'b1;
        raddr_o        = slot_addr(bank_q, end_q);
      end
      S_C_WR: dp_cmd_o.we = 1'b1;
      S_A_WR: begin
        dp_cmd_o.we      = 1'b1;
        dp_cmd_o.wsrc_pt = 1'b1;
      end
      S_FIN: begin
        dp_cmd_o.out_ld  = 1'b1;
        dp_cmd_o.out_sel = ich_pkg::OUT_POINT;
      end
      S_RD0: begin
        dp_cmd_o.out_ld  = (size_q == '0);
        dp_cmd_o.out_sel = ich_pkg::OUT_ZERO;
      end
      S_R_EM: begin
        dp_cmd_o.out_ld  = 1'b1;
        dp_cmd_o.out_sel = ich_pkg::OUT_VERT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      size_q   <= '0;
      head_q   <= '0;
      bank_q   <= 1'b0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
      status_q <= '0;
      count_q  <= '0;
      st_q     <= ich_pkg::ST_ADDED;
      k_q      <= '0;
      j_q      <= '0;
      ptr_q    <= '0;
      beg_q    <= '0;
      end_q    <= '0;
      gap_q    <= '0;
      off_q    <= '0;
      x1pos_q  <= 1'b0;
      hb_q     <= 1'b0;
      he_q     <= 1'b0;
      add_q    <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= cmd_i ? S_RD0 : S_INS;
          end
        end
        S_INS: begin
          if (size_q == '0) begin
            size_q  <= SW'(1);
            head_q  <= '0;
            st_q    <= ich_pkg::ST_ADDED;
            state_q <= S_FIN;
          end else if (size_q == SW'(1)) begin
            state_q <= S_ONE_SH;
          end else begin
            ptr_q   <= head_q;
            state_q <= S_PRE_SH;
          end
        end
        S_ONE_SH: state_q <= S_ONE_EQ;
        S_ONE_EQ: begin
          if (sts_i.eq_b) begin
            head_q <= '0;
            st_q   <= ich_pkg::ST_REPLACED;
          end else begin
            size_q <= SW'(2);
            st_q   <= ich_pkg::ST_ADDED;
          end
          state_q <= S_FIN;
        end
        S_PRE_SH:  state_q <= S_PRE_SH2;
        S_PRE_SH2: state_q <= S_PRE_W1;
        S_PRE_W1:  state_q <= S_PRE_W2;
        S_PRE_W2:  state_q <= S_PRE_US;
        S_PRE_US: begin
          x1pos_q <= sts_i.cross_pos;
          k_q     <= '0;
          hb_q    <= 1'b0;
          he_q    <= 1'b0;
          state_q <= S_L_RD;
        end
        S_L_RD: state_q <= S_L_SH;
        S_L_SH: state_q <= S_L_EQ;
        S_L_EQ: begin
          if (sts_i.eq_a) begin
            head_q  <= ptr_q;
            st_q    <= ich_pkg::ST_REPLACED;
            state_q <= S_FIN;
          end else begin
            state_q <= S_L_W;
          end
        end
        S_L_W: state_q <= S_L_US;
        S_L_US: begin
          if (x1pos_q && !sts_i.cross_pos) begin
            beg_q <= ptr_q;
            hb_q  <= 1'b1;
          end else if (!x1pos_q && sts_i.cross_pos) begin
            end_q <= ptr_q;
            he_q  <= 1'b1;
          end
          x1pos_q <= sts_i.cross_pos;
          ptr_q   <= wrap_inc(ptr_q, size_q);
          k_q     <= k_q + 1'b1;
          state_q <= (k_q == size_q - 1'b1) ? S_CHK : S_L_RD;
        end
        S_CHK: begin
          if (!(hb_q && he_q)) begin
            st_q    <= (size_q == SW'(2)) ? ich_pkg::ST_COLLINEAR : ich_pkg::ST_INTERIOR;
            state_q <= S_FIN;
          end else begin
            gap_q   <= gap_c;
            off_q   <= off_c;
            state_q <= S_T_SH;
          end
        end
        S_T_SH:  state_q <= S_T_SH2;
        S_T_SH2: state_q <= S_T_W1;
        S_T_W1:  state_q <= S_T_W2;
        S_T_W2:  state_q <= S_T_US;
        S_T_US: begin
          j_q     <= '0;
          ptr_q   <= beg_q;
          first_q <= 1'b1;
          k_q     <= size_q - 1'b1 - {1'b0, gap_q};
          if (sts_i.cross_zero) begin
            add_q   <= 1'b0;
            st_q    <= ich_pkg::ST_COLLINEAR;
            state_q <= S_C_RD;
          end else if (gap_q == '0 && size_q == SW'(HULL_DEPTH)) begin
            st_q    <= ich_pkg::ST_OVERFLOW;
            state_q <= S_FIN;
          end else begin
            add_q   <= 1'b1;
            st_q    <= ich_pkg::ST_ADDED;
            state_q <= S_C_RD;
          end
        end
        S_C_RD: state_q <= S_C_WR;
        S_C_WR: begin
          j_q <= j_q + 1'b1;
          if (first_q) begin
            // tangent vertex kept, the run resumes at the second tangent
            first_q <= 1'b0;
            ptr_q   <= end_q;
            if (add_q) begin
              state_q <= S_A_WR;
            end else begin
              state_q <= (k_q == '0) ? S_COMMIT : S_C_RD;
            end
          end else begin
            ptr_q   <= wrap_inc(ptr_q, size_q);
            k_q     <= k_q - 1'b1;
            state_q <= (k_q == SW'(1)) ? S_COMMIT : S_C_RD;
          end
        end
        S_A_WR: begin
          j_q     <= j_q + 1'b1;
          state_q <= (k_q == '0) ? S_COMMIT : S_C_RD;
        end
        S_COMMIT: begin
          bank_q <= !bank_q;
          size_q <= j_q;
          if (add_q) begin
            head_q <= AW'(1);
          end else if (off_q == '0 || off_q <= gap_q) begin
            head_q <= '0;
          end else begin
            head_q <= off_q - gap_q;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          valid_q  <= 1'b1;
          status_q <= st_q;
          last_q   <= 1'b1;
          count_q  <= ich_pkg::CountW'(size_q);
          state_q  <= S_IDLE;
        end
        S_RD0: begin
          if (size_q == '0) begin
            valid_q  <= 1'b1;
            status_q <= ich_pkg::ST_EMPTY;
            last_q   <= 1'b1;
            count_q  <= '0;
            state_q  <= S_IDLE;
          end else begin
            ptr_q   <= head_q;
            k_q     <= '0;
            state_q <= S_R_RD;
          end
        end
        S_R_RD: state_q <= S_R_SH;
        S_R_SH: state_q <= S_R_EM;
        S_R_EM: begin
          valid_q  <= 1'b1;
          status_q <= ich_pkg::ST_VERTEX;
          last_q   <= (k_q == size_q - 1'b1);
          count_q  <= ich_pkg::CountW'(size_q);
          k_q      <= k_q + 1'b1;
          ptr_q    <= wrap_inc(ptr_q, size_q);
          state_q  <= (k_q == size_q - 1'b1) ? S_IDLE : S_R_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign vertex_count_o = count_q;
  assign last_o         = last_q;

endmodule

FILE: rtl/incremental_convex_hull.sv
// insert: n hull vertices are scanned in turn with a shared cross-product unit,
// then up to n vertices are copied into the spare ring bank, each with a read and a write;
// the result strobe comes in the first cycle with busy low
// read: one result per vertex, a single empty result if none; start is taken when busy is low
// reset clears ring size, head and arrival counter; the vertex memory is not cleared
module incremental_convex_hull #(
  parameter int unsigned HULL_DEPTH  = ich_pkg::HullDepthDef,
  parameter int unsigned COORD_WIDTH = ich_pkg::CoordWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        cmd_i,
  input  logic [ich_pkg::PortW-1:0]   x_coord_i,
  input  logic [ich_pkg::PortW-1:0]   y_coord_i,
  output logic                        result_valid_o,
  output logic [2:0]                  status_o,
  output logic [ich_pkg::CountW-1:0]  vertex_count_o,
  output logic [ich_pkg::ArrW-1:0]    vertex_number_o,
  output logic [ich_pkg::PortW-1:0]   vertex_x_o,
  output logic [ich_pkg::PortW-1:0]   vertex_y_o,
  output logic                        last_o
);

  localparam int unsigned RamAw = $clog2(2 * HULL_DEPTH);

  ich_pkg::dp_cmd_t  dp_cmd;
  ich_pkg::dp_sts_t  dp_sts;
  logic [RamAw-1:0]  raddr, waddr;

  ich_ctrl #(
    .HULL_DEPTH (HULL_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .sts_i          (dp_sts),
    .dp_cmd_o       (dp_cmd),
    .raddr_o        (raddr),
    .waddr_o        (waddr),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .vertex_count_o (vertex_count_o),
    .last_o         (last_o)
  );

  ich_dp #(
    .HULL_DEPTH  (HULL_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .x_coord_i       (x_coord_i),
    .y_coord_i       (y_coord_i),
    .cmd_i           (dp_cmd),
    .raddr_i         (raddr),
    .waddr_i         (waddr),
    .sts_o           (dp_sts),
    .vertex_number_o (vertex_number_o),
    .vertex_x_o      (vertex_x_o),
    .vertex_y_o      (vertex_y_o)
  );

endmodule

FILE: rtl/ich_checker.sv
module ich_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       result_valid_o,
  input logic [2:0]                 status_o,
  input logic [ich_pkg::CountW-1:0] vertex_count_o,
  input logic                       last_o
);

  // an accepted request always occupies the block
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request accepted but block not busy");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result directly after final result");

  a_mid_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> status_o == ich_pkg::ST_VERTEX)
    else $error("non-final result that is not a vertex");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ich_pkg::ST_EMPTY |-> last_o && vertex_count_o == '0)
    else $error("empty read with vertices or without final flag");

endmodule

bind incremental_convex_hull ich_checker u_ich_checker (.*);
